// File: rtl/core/imu_serial_frame_parser_defines.svh
// Assertion macros for the RTL of the IMU frame parser.
`ifndef IMU_SERIAL_FRAME_PARSER_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMU_SFP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("imu frame parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IMU_SFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("imu frame parser: next-cycle check failed");

`endif

// File: rtl/core/imu_sfp_pkg.sv
package imu_sfp_pkg;

    localparam int FrameLen = 11;
    localparam int SumLen   = 10;
    localparam int FillW    = $clog2(FrameLen);

    localparam logic [7:0] SyncByte  = 8'h55;
    localparam logic [7:0] TypeAcc   = 8'h51;
    localparam logic [7:0] TypeAvel  = 8'h52;
    localparam logic [7:0] TypeAngle = 8'h53;
    localparam logic [7:0] TypeMag   = 8'h54;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_AVEL  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_MAG   = 2'd3
    } frame_kind_t;

    // Byte 0 of the frame sits at index 0.
    typedef logic [FrameLen-1:0][7:0] frame_win_t;

    typedef struct packed {
        logic               frame_ok;
        logic               known;
        frame_kind_t        kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] aux_word;
        logic signed [17:0] temp_total;
        logic signed [17:0] accum_next;
    } frame_dec_t;

endpackage

// File: rtl/core/imu_sfp_decode.sv
module imu_sfp_decode (
    input  imu_sfp_pkg::frame_win_t win_i,
    input  logic signed [17:0]      accum_i,
    output imu_sfp_pkg::frame_dec_t dec_o
);
    import imu_sfp_pkg::*;

    logic [7:0]         pair_sum [SumLen/2];
    logic [7:0]         byte_sum;
    logic signed [15:0] aux;
    logic signed [18:0] wide_sum;
    logic signed [17:0] sat_sum;

    always_comb begin
        for (int i = 0; i < SumLen/2; i++) begin
            pair_sum[i] = win_i[2*i] + win_i[2*i+1];
        end
        byte_sum = ((pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3])) + pair_sum[4];
    end

    assign aux      = $signed({win_i[9], win_i[8]});
    assign wide_sum = $signed({accum_i[17], accum_i}) + $signed({{3{aux[15]}}, aux});

    // The sum of two in-range values overflows 18 bits only by one bit, so the
    // top two bits disagreeing is enough to detect it.
    always_comb begin
        if (wide_sum[18] != wide_sum[17]) begin
            sat_sum = wide_sum[18] ? {1'b1, 17'd0} : {1'b0, {17{1'b1}}};
        end else begin
            sat_sum = wide_sum[17:0];
        end
    end

    always_comb begin
        dec_o.frame_ok   = (win_i[0] == SyncByte) && (byte_sum == win_i[10]);
        dec_o.known      = 1'b1;
        dec_o.kind       = KIND_ACC;
        dec_o.axis_x     = $signed({win_i[3], win_i[2]});
        dec_o.axis_y     = $signed({win_i[5], win_i[4]});
        dec_o.axis_z     = $signed({win_i[7], win_i[6]});
        dec_o.aux_word   = aux;
        dec_o.temp_total = '0;
        dec_o.accum_next = accum_i;
        case (win_i[1])
            TypeAcc: begin
                dec_o.kind       = KIND_ACC;
                dec_o.accum_next = {{2{aux[15]}}, aux};
            end
            TypeAvel: begin
                dec_o.kind       = KIND_AVEL;
                dec_o.accum_next = sat_sum;
            end
            TypeAngle: begin
                dec_o.kind       = KIND_ANGLE;
                dec_o.temp_total = sat_sum;
                dec_o.accum_next = '0;
            end
            TypeMag: begin
                dec_o.kind = KIND_MAG;
            end
            default: begin
                dec_o.known = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/imu_serial_frame_parser.sv
// Byte-serial parser for 11-byte IMU frames.
// The s_ channel carries one received serial byte per beat (s_rx_byte). The
// m_ channel carries one decoded frame per beat: the frame kind, the four raw
// signed words of bytes 2 to 9 and, on angle frames, the saturated temperature
// sum that an acceleration frame starts and each angular-rate and angle frame adds to.
// A frame is reported when the eleventh byte of a window starting with the
// sync byte 0x55 and ending in a matching byte-sum checksum arrives and its
// type byte is known; any other window either slides by one byte or, for an
// unknown type, is dropped without a beat on the m_ channel.
// A closing byte is held in the input register and its result in the result
// register, which drives m_valid. Throughput: one byte per cycle unless m_ready
// holds the result register, limited by the combinational checksum tree and
// window update between the two registers.
// When the receiver holds m_ready low, the result register keeps its beat and
// one further byte is held in the input register before s_ready drops.
// A synchronous active-low reset empties both registers, the byte window and
// the temperature accumulator; no clearing pass is needed afterwards.
`include "imu_serial_frame_parser_defines.svh"

module imu_serial_frame_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_kind,
    output logic signed [15:0] m_axis_x,
    output logic signed [15:0] m_axis_y,
    output logic signed [15:0] m_axis_z,
    output logic signed [15:0] m_aux_word,
    output logic signed [17:0] m_temp_total
);
    import imu_sfp_pkg::*;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic [SumLen-1:0][7:0]      win_reg;
    logic [FillW-1:0]            fill_reg;
    logic signed [17:0]          temp_accum_reg;
    logic                        out_valid_reg;
    frame_kind_t                 out_kind_reg;
    logic signed [15:0]          out_x_reg;
    logic signed [15:0]          out_y_reg;
    logic signed [15:0]          out_z_reg;
    logic signed [15:0]          out_aux_reg;
    logic signed [17:0]          out_total_reg;

    logic       proc_fire;
    logic       win_full;
    logic       produce;
    frame_win_t frame_win;
    frame_dec_t dec;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign win_full  = (fill_reg == FillW'(SumLen));
    // The new byte completes the window as byte 10.
    assign frame_win = {in_byte_reg, win_reg};
    assign produce   = win_full && dec.frame_ok && dec.known;

    imu_sfp_decode u_decode (
        .win_i   (frame_win),
        .accum_i (temp_accum_reg),
        .dec_o   (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            fill_reg       <= '0;
            temp_accum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                if (!win_full) begin
                    fill_reg <= fill_reg + FillW'(1);
                end else if (dec.frame_ok) begin
                    fill_reg <= '0;
                    if (dec.known) begin
                        temp_accum_reg <= dec.accum_next;
                    end
                end
                out_valid_reg <= produce;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (proc_fire) begin
            if (!win_full) begin
                win_reg[fill_reg] <= in_byte_reg;
            end else if (!dec.frame_ok) begin
                // Failed check: drop the oldest byte, keep ten.
                win_reg <= {in_byte_reg, win_reg[SumLen-1:1]};
            end
        end
        if (proc_fire && produce) begin
            out_kind_reg  <= dec.kind;
            out_x_reg     <= dec.axis_x;
            out_y_reg     <= dec.axis_y;
            out_z_reg     <= dec.axis_z;
            out_aux_reg   <= dec.aux_word;
            out_total_reg <= dec.temp_total;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_kind = out_kind_reg;
    assign m_axis_x     = out_x_reg;
    assign m_axis_y     = out_y_reg;
    assign m_axis_z     = out_z_reg;
    assign m_aux_word   = out_aux_reg;
    assign m_temp_total = out_total_reg;

    `IMU_SFP_ASSERT_NOW(a_fill_in_range, aclk, aresetn, 1'b1, fill_reg <= FillW'(SumLen))
    `IMU_SFP_ASSERT_NEXT(a_no_result_while_filling, aclk, aresetn, proc_fire && !win_full, !out_valid_reg)
    `IMU_SFP_ASSERT_NEXT(a_good_frame_empties_window, aclk, aresetn, proc_fire && win_full && dec.frame_ok, fill_reg == '0)
    `IMU_SFP_ASSERT_NEXT(a_angle_clears_accum, aclk, aresetn, proc_fire && produce && dec.kind == KIND_ANGLE, temp_accum_reg == '0)

endmodule

// File: tb/imu_sfp_frame_checker.sv
module imu_sfp_frame_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_frame_kind,
    input  logic signed [15:0] m_axis_x,
    input  logic signed [15:0] m_axis_y,
    input  logic signed [15:0] m_axis_z,
    input  logic signed [15:0] m_aux_word,
    input  logic signed [17:0] m_temp_total,
    output int                 frames_pending,
    output int                 fail_count
);
    import imu_sfp_pkg::*;

    localparam int TempMax = 131071;
    localparam int TempMin = -131072;

    typedef struct {
        frame_kind_t        kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] aux_word;
        logic signed [17:0] temp_total;
    } decoded_frame_t;

    decoded_frame_t     expected_frames[$];
    logic [7:0]         rx_window [0:FrameLen-1];
    int                 window_fill;
    logic signed [17:0] temp_sum;

    initial begin
        fail_count     = 0;
        frames_pending = 0;
    end

    function automatic logic signed [17:0] clamp_temp(input int v);
        if (v > TempMax) begin
            return TempMax[17:0];
        end
        if (v < TempMin) begin
            return TempMin[17:0];
        end
        return v[17:0];
    endfunction

    // Takes one byte into the window and queues the frame it completes, if any.
    task automatic decode_byte(input logic [7:0] rx);
        logic [7:0]     checksum;
        decoded_frame_t frame;
        bit             known;
        int             i;
        rx_window[window_fill] = rx;
        window_fill++;
        if (window_fill < FrameLen) begin
            return;
        end
        checksum = '0;
        for (i = 0; i < SumLen; i++) begin
            checksum += rx_window[i];
        end
        if (rx_window[0] != SyncByte || checksum != rx_window[FrameLen-1]) begin
            for (i = 0; i < FrameLen - 1; i++) begin
                rx_window[i] = rx_window[i+1];
            end
            rx_window[FrameLen-1] = '0;
            window_fill = FrameLen - 1;
            return;
        end
        window_fill      = 0;
        frame.axis_x     = {rx_window[3], rx_window[2]};
        frame.axis_y     = {rx_window[5], rx_window[4]};
        frame.axis_z     = {rx_window[7], rx_window[6]};
        frame.aux_word   = {rx_window[9], rx_window[8]};
        frame.temp_total = '0;
        frame.kind       = KIND_ACC;
        known            = 1'b1;
        case (rx_window[1])
            TypeAcc: begin
                temp_sum = frame.aux_word;
            end
            TypeAvel: begin
                frame.kind = KIND_AVEL;
                temp_sum   = clamp_temp(int'(temp_sum) + int'(frame.aux_word));
            end
            TypeAngle: begin
                frame.kind       = KIND_ANGLE;
                frame.temp_total = clamp_temp(int'(temp_sum) + int'(frame.aux_word));
                temp_sum         = '0;
            end
            TypeMag: begin
                frame.kind = KIND_MAG;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        if (known) begin
            expected_frames.push_back(frame);
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        decoded_frame_t want;
        if (!aresetn) begin
            expected_frames.delete();
            for (int i = 0; i < FrameLen; i++) begin
                rx_window[i] = '0;
            end
            window_fill = 0;
            temp_sum    = '0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, kind %0d x %0d y %0d z %0d aux %0d temp %0d",
                             $time, m_frame_kind, m_axis_x, m_axis_y, m_axis_z, m_aux_word,
                             m_temp_total);
                end else begin
                    want = expected_frames.pop_front();
                    compare_field("frame_kind", longint'(want.kind), longint'(m_frame_kind));
                    compare_field("axis_x", want.axis_x, m_axis_x);
                    compare_field("axis_y", want.axis_y, m_axis_y);
                    compare_field("axis_z", want.axis_z, m_axis_z);
                    compare_field("aux_word", want.aux_word, m_aux_word);
                    compare_field("temp_total", want.temp_total, m_temp_total);
                end
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

// File: tb/tb_imu_serial_frame_parser.sv
module tb_imu_serial_frame_parser;

    import imu_sfp_pkg::*;

    localparam int         RandomBytes  = 1450;
    localparam int         QuietLimit   = 1000;
    localparam int         HoldOffStart = 1500;
    localparam int         HoldOffLen   = 80;
    localparam logic [7:0] NoFlip       = 8'h00;
    localparam logic [7:0] BadSync      = 8'hAA;
    localparam logic [7:0] TypeUnknownA = 8'h50;
    localparam logic [7:0] TypeUnknownB = 8'h00;
    localparam logic [7:0] TypeUnknownC = 8'hFF;
    localparam logic [15:0] WordMax     = 16'h7FFF;
    localparam logic [15:0] WordMin     = 16'h8000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [1:0]         m_frame_kind;
    logic signed [15:0] m_axis_x;
    logic signed [15:0] m_axis_y;
    logic signed [15:0] m_axis_z;
    logic signed [15:0] m_aux_word;
    logic signed [17:0] m_temp_total;
    int                 frames_pending;
    int                 fail_count;
    int                 bytes_sent = 0;
    int                 quiet_cycles = 0;
    bit                 steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    imu_serial_frame_parser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_kind (m_frame_kind),
        .m_axis_x     (m_axis_x),
        .m_axis_y     (m_axis_y),
        .m_axis_z     (m_axis_z),
        .m_aux_word   (m_aux_word),
        .m_temp_total (m_temp_total)
    );

    imu_sfp_frame_checker u_frame_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_kind   (m_frame_kind),
        .m_axis_x       (m_axis_x),
        .m_axis_y       (m_axis_y),
        .m_axis_z       (m_axis_z),
        .m_aux_word     (m_aux_word),
        .m_temp_total   (m_temp_total),
        .frames_pending (frames_pending),
        .fail_count     (fail_count)
    );

    task automatic send_byte(input logic [7:0] rx);
        while (!steady && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
        // A stretch in the middle of the random part runs without any idling.
        steady = (bytes_sent >= 800 && bytes_sent < 1100);
    endtask

    task automatic send_frame(input logic [7:0] sync, input logic [7:0] kind_byte,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic [15:0] aux,
                              input logic [7:0] sum_flip);
        logic [7:0] frame_bytes [0:FrameLen-1];
        logic [7:0] checksum;
        int         i;
        frame_bytes[0] = sync;
        frame_bytes[1] = kind_byte;
        frame_bytes[2] = x[7:0];
        frame_bytes[3] = x[15:8];
        frame_bytes[4] = y[7:0];
        frame_bytes[5] = y[15:8];
        frame_bytes[6] = z[7:0];
        frame_bytes[7] = z[15:8];
        frame_bytes[8] = aux[7:0];
        frame_bytes[9] = aux[15:8];
        checksum = '0;
        for (i = 0; i < SumLen; i++) begin
            checksum += frame_bytes[i];
        end
        frame_bytes[FrameLen-1] = checksum ^ sum_flip;
        for (i = 0; i < FrameLen; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    task automatic send_random_frame(input logic [7:0] kind_byte);
        logic [15:0] aux;
        logic [7:0]  sync;
        logic [7:0]  flip;
        int          roll;
        int          noise;
        roll = $urandom_range(0, 99);
        aux  = (roll < 15) ? WordMax : (roll < 30) ? WordMin : 16'($urandom);
        roll = $urandom_range(0, 99);
        sync = (roll < 4) ? 8'($urandom) : SyncByte;
        flip = (roll >= 4 && roll < 12) ? 8'($urandom_range(1, 255)) : NoFlip;
        if ($urandom_range(0, 99) < 15) begin
            noise = $urandom_range(1, 5);
            repeat (noise) begin
                send_byte(8'($urandom));
            end
        end
        send_frame(sync, kind_byte, 16'($urandom), 16'($urandom), 16'($urandom), aux, flip);
    endtask

    function automatic logic [7:0] random_kind_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return 8'($urandom);
        end
        case (roll % 4)
            0:       return TypeAcc;
            1:       return TypeAvel;
            2:       return TypeAngle;
            default: return TypeMag;
        endcase
    endfunction

    initial begin
        int stop_at;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extreme words, and a positive temperature sum driven into saturation.
        send_frame(SyncByte, TypeAcc, WordMax, WordMin, 16'h0000, WordMax, NoFlip);
        repeat (4) begin
            send_frame(SyncByte, TypeAvel, 16'hFFFF, 16'h0001, WordMax, WordMax, NoFlip);
        end
        send_frame(SyncByte, TypeAngle, WordMin, WordMax, 16'hFFFF, WordMax, NoFlip);
        send_frame(SyncByte, TypeMag, 16'h1234, 16'hEDCB, WordMin, WordMin, NoFlip);
        // The same towards the negative limit.
        send_frame(SyncByte, TypeAcc, 16'h0000, 16'h0000, 16'h0000, WordMin, NoFlip);
        repeat (4) begin
            send_frame(SyncByte, TypeAvel, WordMin, WordMin, WordMin, WordMin, NoFlip);
        end
        send_frame(SyncByte, TypeAngle, WordMax, WordMax, WordMax, WordMin, NoFlip);
        // An angle frame straight after another one starts from a cleared sum.
        send_frame(SyncByte, TypeAngle, 16'h00FF, 16'hFF00, 16'h5555, 16'h1234, NoFlip);
        send_frame(SyncByte, TypeUnknownA, 16'h1111, 16'h2222, 16'h3333, 16'h4444, NoFlip);
        send_frame(SyncByte, TypeUnknownB, 16'h0000, 16'h0000, 16'h0000, 16'h0000, NoFlip);
        send_frame(SyncByte, TypeUnknownC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, NoFlip);
        send_frame(SyncByte, TypeAcc, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 8'h01);
        send_frame(BadSync, TypeAcc, 16'h0102, 16'h0304, 16'h0506, 16'h0708, NoFlip);
        // False sync bytes ahead of a good frame make the window slide.
        send_byte(SyncByte);
        send_byte(SyncByte);
        send_byte(8'h00);
        send_frame(SyncByte, TypeAcc, 16'h0010, 16'hFFF0, 16'h0100, 16'h0064, NoFlip);
        send_frame(SyncByte, TypeAvel, 16'h0020, 16'hFFE0, 16'h0200, 16'hFF9C, NoFlip);
        send_frame(SyncByte, TypeAngle, 16'h0030, 16'hFFD0, 16'h0300, 16'h00C8, NoFlip);

        stop_at = bytes_sent + RandomBytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 99) < 50) begin
                send_random_frame(TypeAcc);
                repeat ($urandom_range(0, 5)) begin
                    send_random_frame(TypeAvel);
                end
                if ($urandom_range(0, 99) < 20) begin
                    send_random_frame(TypeMag);
                end
                send_random_frame(TypeAngle);
            end else begin
                send_random_frame(random_kind_byte());
            end
        end
        s_valid <= 1'b0;

        // The checker updates its count at the rising edge, so it is read at the falling one.
        @(negedge aclk);
        while (frames_pending != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("imu_serial_frame_parser test passed");
        end else begin
            $display("imu_serial_frame_parser test failed");
        end
        $finish;
    end

    initial begin
        int cycle;
        cycle = 0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            cycle++;
            if (cycle == HoldOffStart) begin
                // Long hold-off so that the block fills up and stalls its input.
                m_ready <= 1'b0;
                repeat (HoldOffLen) @(posedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 29);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QuietLimit) begin
                $display("imu_serial_frame_parser test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
